// ===== rtl/csv_line_field_parser_defines.svh =====
// Assertion macros used by the top-level RTL module.
`ifndef CSV_LINE_FIELD_PARSER_DEFINES_SVH
`define CSV_LINE_FIELD_PARSER_DEFINES_SVH

// Check that an implication holds at every clock edge outside reset.
`define CLP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check that an implication holds in the cycle after its antecedent.
`define CLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/clp_pkg.sv =====
package clp_pkg;

   localparam int MaxColumns    = 16;
   localparam int LineLengthMax = 65535;

   localparam logic [7:0] QuoteChar = 8'd34;
   localparam logic [7:0] LfChar    = 8'd10;
   localparam logic [7:0] CrChar    = 8'd13;

   // Column type codes of the column_types register.
   localparam logic [3:0] ColBytes  = 4'd0;
   localparam logic [3:0] ColInt64  = 4'd1;
   localparam logic [3:0] ColInt32  = 4'd2;
   localparam logic [3:0] ColUint64 = 4'd3;
   localparam logic [3:0] ColUint32 = 4'd4;
   localparam logic [3:0] ColBool   = 4'd5;

   // Value type codes of a result.
   localparam logic [2:0] VtNull   = 3'd0;
   localparam logic [2:0] VtInt64  = 3'd1;
   localparam logic [2:0] VtInt32  = 3'd2;
   localparam logic [2:0] VtUint64 = 3'd3;
   localparam logic [2:0] VtUint32 = 3'd4;
   localparam logic [2:0] VtBool   = 3'd5;
   localparam logic [2:0] VtBytes  = 3'd6;

   // Row status codes.
   localparam logic [1:0] StOk       = 2'd0;
   localparam logic [1:0] StQuote    = 2'd1;
   localparam logic [1:0] StMismatch = 2'd2;

   // Register indexes.
   localparam logic [2:0] RegDelimiter = 3'd0;
   localparam logic [2:0] RegQuotes    = 3'd1;
   localparam logic [2:0] RegEmptyNull = 3'd2;
   localparam logic [2:0] RegExpCols   = 3'd3;
   localparam logic [2:0] RegColTypes  = 3'd4;

   // Bool matcher states.
   localparam logic [3:0] BoolStart = 4'd0;
   localparam logic [3:0] BoolT    = 4'd1;
   localparam logic [3:0] BoolTr   = 4'd2;
   localparam logic [3:0] BoolTru  = 4'd3;
   localparam logic [3:0] BoolTrue = 4'd4;
   localparam logic [3:0] BoolF    = 4'd5;
   localparam logic [3:0] BoolFa   = 4'd6;
   localparam logic [3:0] BoolFal  = 4'd7;
   localparam logic [3:0] BoolFals = 4'd8;
   localparam logic [3:0] BoolFalse = 4'd9;
   localparam logic [3:0] BoolOne  = 4'd10;
   localparam logic [3:0] BoolZero = 4'd11;
   localparam logic [3:0] BoolFail = 4'd15;

   typedef struct packed {
      logic [7:0]  delimiter;
      logic        quotes_en;
      logic        null_on_empty;
      logic [4:0]  expected_columns;
      logic [63:0] column_types;
   } cfg_type;

   // Per-field accumulation state.
   typedef struct packed {
      logic [15:0] content_length;
      logic [15:0] trailing_space_count;
      logic        seen_nonspace;
      logic [1:0]  number_phase;
      logic        negative_sign;
      logic [63:0] magnitude;
      logic        overflowed;
      logic        number_invalid;
      logic [3:0]  bool_match;
   } field_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  column;
      logic [2:0]  value_type;
      logic [63:0] field_value;
      logic [15:0] byte_length;
      logic [1:0]  row_status;
      logic        last;
   } result_type;

   // Per-byte update of the bool matcher.
   function automatic logic [3:0] bool_next(input logic [3:0] s, input logic [7:0] ch);
      logic [7:0] c;
      logic [3:0] r;
      c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      r = BoolFail;
      case (s)
         BoolStart: begin
            if (c == "t") r = BoolT;
            else if (c == "f") r = BoolF;
            else if (c == "1") r = BoolOne;
            else if (c == "0") r = BoolZero;
         end
         BoolT:   if (c == "r") r = BoolTr;
         BoolTr:  if (c == "u") r = BoolTru;
         BoolTru: if (c == "e") r = BoolTrue;
         BoolF:   if (c == "a") r = BoolFa;
         BoolFa:  if (c == "l") r = BoolFal;
         BoolFal: if (c == "s") r = BoolFals;
         BoolFals: if (c == "e") r = BoolFalse;
         default: r = BoolFail;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/clp_stream_if.sv =====
interface clp_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/clp_csr.sv =====
module clp_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [5:0]           csr_paddr,
   input  logic [63:0]          csr_pwdata,
   output logic [63:0]          csr_prdata,
   output logic                 csr_pready,
   output clp_pkg::cfg_type     cfg
);
   clp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0] index;
   logic       write_en;

   assign index      = csr_paddr[5:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            clp_pkg::RegDelimiter: cfg_in.delimiter        = csr_pwdata[7:0];
            clp_pkg::RegQuotes:    cfg_in.quotes_en        = csr_pwdata[0];
            clp_pkg::RegEmptyNull: cfg_in.null_on_empty    = csr_pwdata[0];
            clp_pkg::RegExpCols:   cfg_in.expected_columns = csr_pwdata[4:0];
            clp_pkg::RegColTypes:  cfg_in.column_types     = csr_pwdata;
            default: ;
         endcase
      end
   end

   // Read mux.
   always_comb begin
      csr_prdata = '0;
      unique case (index)
         clp_pkg::RegDelimiter: csr_prdata[7:0] = cfg_ff.delimiter;
         clp_pkg::RegQuotes:    csr_prdata[0]   = cfg_ff.quotes_en;
         clp_pkg::RegEmptyNull: csr_prdata[0]   = cfg_ff.null_on_empty;
         clp_pkg::RegExpCols:   csr_prdata[4:0] = cfg_ff.expected_columns;
         clp_pkg::RegColTypes:  csr_prdata      = cfg_ff.column_types;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delimiter        <= 8'd44;
         cfg_ff.quotes_en        <= 1'b1;
         cfg_ff.null_on_empty    <= 1'b0;
         cfg_ff.expected_columns <= 5'd0;
         cfg_ff.column_types     <= 64'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== rtl/clp_convert.sv =====
// Turns the finished field state into a result item.
module clp_convert (
   input  clp_pkg::cfg_type    cfg,
   input  clp_pkg::field_type  fld,
   input  logic [7:0]          field_index,
   input  logic                result_kind,
   input  logic [1:0]          row_status,
   output clp_pkg::result_type res
);
   logic [3:0]  raw_type;
   logic [3:0]  col_type;
   logic        num_ok;
   logic [63:0] sv;
   logic [15:0] len;

   always_comb begin
      raw_type = cfg.column_types[{field_index[3:0], 2'b00} +: 4];
      col_type = clp_pkg::ColBytes;
      if (cfg.expected_columns != 5'd0 && field_index < 8'(clp_pkg::MaxColumns)
          && raw_type >= clp_pkg::ColInt64 && raw_type <= clp_pkg::ColBool)
         col_type = raw_type;
      len = (fld.content_length >= fld.trailing_space_count) ?
            fld.content_length - fld.trailing_space_count : 16'd0;
      num_ok = !fld.number_invalid && fld.number_phase == 2'd2 && !fld.overflowed;
      sv = fld.negative_sign ? 64'd0 - fld.magnitude : fld.magnitude;

      res.result_kind = result_kind;
      res.column      = field_index;
      res.value_type  = clp_pkg::VtNull;
      res.field_value = 64'd0;
      res.byte_length = len;
      res.row_status  = row_status;
      res.last        = result_kind;

      if (!(!fld.seen_nonspace && cfg.null_on_empty)) begin
         case (col_type)
            clp_pkg::ColInt64:
               if (num_ok && (fld.magnitude[63] == 1'b0 ||
                   (fld.negative_sign && fld.magnitude == 64'h8000000000000000))) begin
                  res.value_type = clp_pkg::VtInt64; res.field_value = sv;
               end
            clp_pkg::ColInt32:
               if (num_ok && (fld.magnitude <= 64'h7FFFFFFF ||
                   (fld.negative_sign && fld.magnitude == 64'h80000000))) begin
                  res.value_type = clp_pkg::VtInt32; res.field_value = sv;
               end
            clp_pkg::ColUint64:
               if (num_ok) begin
                  res.value_type = clp_pkg::VtUint64; res.field_value = sv;
               end
            clp_pkg::ColUint32:
               if (num_ok && sv[63:32] == 32'd0) begin
                  res.value_type = clp_pkg::VtUint32; res.field_value = sv;
               end
            clp_pkg::ColBool: begin
               if (fld.bool_match == clp_pkg::BoolT || fld.bool_match == clp_pkg::BoolTrue
                   || fld.bool_match == clp_pkg::BoolOne) begin
                  res.value_type = clp_pkg::VtBool; res.field_value = 64'd1;
               end else if (fld.bool_match == clp_pkg::BoolF ||
                   fld.bool_match == clp_pkg::BoolFalse ||
                   fld.bool_match == clp_pkg::BoolZero) begin
                  res.value_type = clp_pkg::VtBool;
               end
            end
            default: res.value_type = clp_pkg::VtBytes;
         endcase
      end
   end
endmodule

// ===== rtl/clp_core.sv =====
// Byte scanner: updates line and field state per item and builds up to two results.
module clp_core (
   input  logic                clock,
   input  logic                reset,
   input  clp_pkg::cfg_type    cfg,
   input  logic                accept,
   input  logic [7:0]          c,
   input  logic                eol,
   output logic [1:0]          count,
   output clp_pkg::result_type res0,
   output clp_pkg::result_type res1
);
   clp_pkg::field_type fld_ff, fld_in, fld_mid, fld_add, fld_src;
   logic in_quotes_ff, in_quotes_in, quote_pending_ff, quote_pending_in;
   logic cr_pending_ff, cr_pending_in;
   logic [7:0] index_ff, index_in, index_mid;
   logic emit_cr, emit_delim, do_add, stripped, ws;
   logic [7:0] add_char;
   logic [3:0] d;
   logic [67:0] prod;
   clp_pkg::result_type cr_res, delim_res, end_res;
   logic [1:0] end_status;

   // Pending CR result uses the state on entry.
   clp_convert u_cr (.cfg(cfg), .fld(fld_ff), .field_index(index_ff),
      .result_kind(1'b0), .row_status(clp_pkg::StOk), .res(cr_res));

   always_comb begin
      stripped = eol && (c == clp_pkg::LfChar || c == clp_pkg::CrChar);
      emit_cr  = cr_pending_ff && !(c == clp_pkg::LfChar && eol);
      fld_mid  = emit_cr ? '0 : fld_ff;
      index_mid = (emit_cr && index_ff != 8'd255) ? index_ff + 8'd1 : index_ff;
      in_quotes_in = in_quotes_ff;
      quote_pending_in = quote_pending_ff;
      cr_pending_in = 1'b0;
      emit_delim = 1'b0;
      do_add = 1'b0;
      add_char = c;
      if (!stripped) begin
         if (cfg.quotes_en && c == clp_pkg::QuoteChar) begin
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0; do_add = 1'b1;
            end else if (!in_quotes_ff) in_quotes_in = 1'b1;
            else quote_pending_in = 1'b1;
         end else begin
            if (quote_pending_ff) begin
               quote_pending_in = 1'b0; in_quotes_in = 1'b0;
            end
            if (!in_quotes_in && c == cfg.delimiter) begin
               if (c == clp_pkg::CrChar && !eol) cr_pending_in = 1'b1;
               else emit_delim = 1'b1;
            end else do_add = 1'b1;
         end
      end
   end

   // Content update: trimming, decimal accumulate and bool match.
   always_comb begin
      fld_add = fld_mid;
      ws = add_char == 8'd32 || (add_char >= 8'd9 && add_char <= 8'd13);
      d = add_char[3:0];
      prod = {4'd0, fld_mid.magnitude} * 68'd10 + {64'd0, d};
      if (ws) begin
         if (fld_mid.seen_nonspace) begin
            if (fld_mid.content_length != 16'(clp_pkg::LineLengthMax))
               fld_add.content_length = fld_mid.content_length + 16'd1;
            if (fld_mid.trailing_space_count != 16'(clp_pkg::LineLengthMax))
               fld_add.trailing_space_count = fld_mid.trailing_space_count + 16'd1;
         end
      end else begin
         fld_add.bool_match = clp_pkg::bool_next(fld_mid.bool_match, add_char);
         if (fld_mid.seen_nonspace && fld_mid.trailing_space_count != 16'd0) begin
            fld_add.number_invalid = 1'b1;
            fld_add.bool_match = clp_pkg::BoolFail;
         end
         fld_add.seen_nonspace = 1'b1;
         fld_add.trailing_space_count = 16'd0;
         if (fld_mid.content_length != 16'(clp_pkg::LineLengthMax))
            fld_add.content_length = fld_mid.content_length + 16'd1;
         if (add_char >= "0" && add_char <= "9") begin
            fld_add.number_phase = 2'd2;
            if (prod[67:64] != 4'd0) fld_add.overflowed = 1'b1;
            else fld_add.magnitude = prod[63:0];
         end else if ((add_char == "+" || add_char == "-") && fld_mid.number_phase == 2'd0)
         begin
            fld_add.number_phase = 2'd1;
            fld_add.negative_sign = (add_char == "-");
         end else begin
            fld_add.number_invalid = 1'b1;
         end
      end
      fld_src = do_add ? fld_add : fld_mid;
   end

   // Field closed by the delimiter, and the end-of-row result.
   clp_convert u_delim (.cfg(cfg), .fld(fld_mid), .field_index(index_mid),
      .result_kind(1'b0), .row_status(clp_pkg::StOk), .res(delim_res));

   logic       quotes_end;
   clp_pkg::result_type conv_end;

   always_comb begin
      fld_in   = emit_delim ? '0 : fld_src;
      index_in = (emit_delim && index_mid != 8'd255) ? index_mid + 8'd1 : index_mid;
      quotes_end = in_quotes_in && !quote_pending_in;
      end_status = (cfg.expected_columns != 5'd0 &&
                    ({1'b0, index_in} + 9'd1) != {4'd0, cfg.expected_columns})
                   ? clp_pkg::StMismatch : clp_pkg::StOk;
   end

   clp_convert u_end (.cfg(cfg), .fld(fld_in), .field_index(index_in),
      .result_kind(1'b1), .row_status(end_status), .res(conv_end));

   always_comb begin
      end_res = conv_end;
      if (eol && quotes_end) begin
         end_res.value_type  = clp_pkg::VtNull;
         end_res.field_value = 64'd0;
         end_res.byte_length = 16'd0;
         end_res.row_status  = clp_pkg::StQuote;
      end
      // Order results: pending CR field, delimiter field, end of row.
      count = 2'd0;
      res0 = end_res;
      res1 = end_res;
      if (emit_cr) begin
         res0 = cr_res; count = 2'd1;
         if (emit_delim) begin res1 = delim_res; count = 2'd2; end
         else if (eol) count = 2'd2;
      end else if (emit_delim) begin
         res0 = delim_res; count = 2'd1;
         if (eol) count = 2'd2;
      end else if (eol) count = 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_quotes_ff <= 1'b0; quote_pending_ff <= 1'b0; cr_pending_ff <= 1'b0;
         index_ff <= 8'd0; fld_ff <= '0;
      end else if (accept) begin
         if (eol) begin
            in_quotes_ff <= 1'b0; quote_pending_ff <= 1'b0; cr_pending_ff <= 1'b0;
            index_ff <= 8'd0; fld_ff <= '0;
         end else begin
            in_quotes_ff <= in_quotes_in; quote_pending_ff <= quote_pending_in;
            cr_pending_ff <= cr_pending_in; index_ff <= index_in; fld_ff <= fld_in;
         end
      end
   end
endmodule

// ===== rtl/csv_line_field_parser.sv =====
// Channel   | Direction | Payload
// req       | in        | line_byte, end_of_line
// rsp       | out       | result_kind, column, value_type, field_value, byte_length,
//           |           | row_status, last
// One byte item is taken per cycle; its zero to two results go to a three-entry
// output queue and leave one per cycle while the receiver is ready. The input
// stalls only while the queue lacks room for the worst case of two results.
// Reset is synchronous and restores the register defaults and an empty line
// state. The 64x10 accumulate sets the input path.
`include "csv_line_field_parser_defines.svh"
module csv_line_field_parser (
   input  logic          clock,
   input  logic          reset,
   clp_stream_if.sink    req,
   clp_stream_if.source  rsp,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [5:0]    csr_paddr,
   input  logic [63:0]   csr_pwdata,
   output logic [63:0]   csr_prdata,
   output logic          csr_pready
);
   clp_pkg::cfg_type    cfg;
   clp_pkg::result_type res0, res1, head;
   clp_pkg::result_type q_ff [3];
   clp_pkg::result_type q_in [3];
   logic [1:0] cnt_ff, cnt_in, n_new;
   logic accept, pop, rsp_wait;

   clp_csr u_csr (.clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg);

   // Accept when at most one result is still queued.
   assign req.ready = cnt_ff <= 2'd1;
   assign accept    = req.valid && req.ready;
   assign pop       = rsp.valid && rsp.ready;
   assign rsp.valid = cnt_ff != 2'd0;
   assign head      = q_ff[0];
   assign rsp.payload = head;
   assign rsp_wait  = rsp.valid && !rsp.ready;

   clp_core u_core (.clock, .reset, .cfg, .accept, .c(req.payload[7:0]),
      .eol(req.payload[8]), .count(n_new), .res0, .res1);

   // Result queue: shift out at head, append new results behind survivors.
   always_comb begin
      cnt_in = cnt_ff - {1'b0, pop} + (accept ? n_new : 2'd0);
      q_in = q_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
      end
      if (accept) begin
         if (cnt_ff - {1'b0, pop} == 2'd0) begin
            q_in[0] = res0; q_in[1] = res1;
         end else begin
            q_in[1] = res0; q_in[2] = res1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   `CLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp.valid && $stable(rsp.payload))
   `CLP_ASSERT_IMPL(a_full_stall, clock, reset, cnt_ff >= 2'd2, !req.ready)
   `CLP_ASSERT_IMPL(a_last_kind, clock, reset, rsp.valid, head.last == head.result_kind)
endmodule

// ===== tb/sv/csv_line_field_parser_test.sv =====
module csv_line_field_parser_test;

   localparam int ReqWidth = 9;
   localparam int RspWidth = $bits(clp_pkg::result_type);
   localparam int IdleLimit = 20000;

   // Bytes of a line, as the block sees them.
   typedef struct packed {
      logic       end_of_line;
      logic [7:0] line_byte;
   } line_item_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [5:0] csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic csr_pready;

   clp_stream_if #(.Width(ReqWidth)) req ();
   clp_stream_if #(.Width(RspWidth)) rsp ();

   csv_line_field_parser dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // Shadow configuration and parse state of the predictor.
   clp_pkg::cfg_type   shadow_cfg;
   clp_pkg::field_type fld;
   logic      quoted, quote_seen, cr_held;
   logic [7:0] col_index;

   line_item_type pending_bytes[$];
   clp_pkg::result_type expected_results[$];
   int  mismatches = 0;
   int  idle_cycles;
   bit  hold_off;
   int  hold_count;
   int  burst_left, gap_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Start of a fresh field in the predictor.
   function automatic clp_pkg::field_type empty_field();
      clp_pkg::field_type f;
      f = '0;
      return f;
   endfunction

   function automatic logic [3:0] type_of_column(input logic [7:0] col);
      logic [3:0] t;
      if (shadow_cfg.expected_columns == 0 || col >= clp_pkg::MaxColumns)
         return clp_pkg::ColBytes;
      t = shadow_cfg.column_types[4*col[3:0] +: 4];
      return (t >= clp_pkg::ColInt64 && t <= clp_pkg::ColBool) ? t : clp_pkg::ColBytes;
   endfunction

   function automatic logic [3:0] next_bool_state(input logic [3:0] s, input logic [7:0] ch);
      logic [7:0] c;
      c = (ch >= "A" && ch <= "Z") ? ch + 8'd32 : ch;
      case (s)
         clp_pkg::BoolStart: begin
            if (c == "t") return clp_pkg::BoolT;
            if (c == "f") return clp_pkg::BoolF;
            if (c == "1") return clp_pkg::BoolOne;
            if (c == "0") return clp_pkg::BoolZero;
            return clp_pkg::BoolFail;
         end
         clp_pkg::BoolT: return c == "r" ? clp_pkg::BoolTr : clp_pkg::BoolFail;
         clp_pkg::BoolTr: return c == "u" ? clp_pkg::BoolTru : clp_pkg::BoolFail;
         clp_pkg::BoolTru: return c == "e" ? clp_pkg::BoolTrue : clp_pkg::BoolFail;
         clp_pkg::BoolF: return c == "a" ? clp_pkg::BoolFa : clp_pkg::BoolFail;
         clp_pkg::BoolFa: return c == "l" ? clp_pkg::BoolFal : clp_pkg::BoolFail;
         clp_pkg::BoolFal: return c == "s" ? clp_pkg::BoolFals : clp_pkg::BoolFail;
         clp_pkg::BoolFals: return c == "e" ? clp_pkg::BoolFalse : clp_pkg::BoolFail;
         default: return clp_pkg::BoolFail;
      endcase
   endfunction

   // Converted field as the block should report it.
   function automatic clp_pkg::result_type converted_field(input logic kind,
                                                           input logic [1:0] st,
                                                           input logic lst);
      clp_pkg::result_type r;
      logic [3:0] t;
      logic ok;
      logic [63:0] sv;
      t = type_of_column(col_index);
      ok = !fld.number_invalid && fld.number_phase == 2'd2 && !fld.overflowed;
      sv = fld.negative_sign ? 64'd0 - fld.magnitude : fld.magnitude;
      r = '0;
      r.result_kind = kind;
      r.column = col_index;
      r.byte_length = (fld.content_length >= fld.trailing_space_count) ?
                      fld.content_length - fld.trailing_space_count : 16'd0;
      r.row_status = st;
      r.last = lst;
      r.value_type = clp_pkg::VtNull;
      if (!(!fld.seen_nonspace && shadow_cfg.null_on_empty)) begin
         case (t)
            clp_pkg::ColInt64: if (ok && fld.magnitude <= (fld.negative_sign ?
                             64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF)) begin
               r.value_type = clp_pkg::VtInt64; r.field_value = sv;
            end
            clp_pkg::ColInt32: if (ok && fld.magnitude <= (fld.negative_sign ?
                             64'h80000000 : 64'h7FFFFFFF)) begin
               r.value_type = clp_pkg::VtInt32; r.field_value = sv;
            end
            clp_pkg::ColUint64: if (ok) begin
               r.value_type = clp_pkg::VtUint64; r.field_value = sv;
            end
            clp_pkg::ColUint32: if (ok && sv <= 64'hFFFFFFFF) begin
               r.value_type = clp_pkg::VtUint32; r.field_value = sv;
            end
            clp_pkg::ColBool: begin
               if (fld.bool_match inside {clp_pkg::BoolT, clp_pkg::BoolTrue,
                                          clp_pkg::BoolOne}) begin
                  r.value_type = clp_pkg::VtBool; r.field_value = 64'd1;
               end else if (fld.bool_match inside {clp_pkg::BoolF, clp_pkg::BoolFalse,
                                                   clp_pkg::BoolZero}) begin
                  r.value_type = clp_pkg::VtBool; r.field_value = 64'd0;
               end
            end
            default: r.value_type = clp_pkg::VtBytes;
         endcase
      end
      return r;
   endfunction

   // Accumulates one content byte into the current field.
   function automatic void append_content(input logic [7:0] c);
      logic [3:0] d;
      if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
         if (!fld.seen_nonspace) return;
         if (fld.content_length != 16'hFFFF) fld.content_length++;
         if (fld.trailing_space_count != 16'hFFFF) fld.trailing_space_count++;
         return;
      end
      if (fld.seen_nonspace && fld.trailing_space_count != 0) begin
         fld.number_invalid = 1'b1;
         fld.bool_match = clp_pkg::BoolFail;
      end
      fld.seen_nonspace = 1'b1;
      fld.trailing_space_count = '0;
      if (fld.content_length != 16'hFFFF) fld.content_length++;
      if (c >= "0" && c <= "9") begin
         d = c[3:0];
         fld.number_phase = 2'd2;
         if (fld.magnitude > (64'hFFFFFFFFFFFFFFFF - d) / 10) fld.overflowed = 1'b1;
         else fld.magnitude = fld.magnitude * 10 + d;
      end else if ((c == "+" || c == "-") && fld.number_phase == 2'd0) begin
         fld.number_phase = 2'd1;
         fld.negative_sign = (c == "-");
      end else begin
         fld.number_invalid = 1'b1;
      end
      fld.bool_match = next_bool_state(fld.bool_match, c);
   endfunction

   function automatic void add_expected(input clp_pkg::result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   function automatic void close_field();
      add_expected(converted_field(1'b0, clp_pkg::StOk, 1'b0));
      if (col_index != 8'd255) col_index++;
      fld = empty_field();
   endfunction

   function automatic void clear_line_state();
      quoted = 0; quote_seen = 0; cr_held = 0; col_index = '0;
      fld = empty_field();
   endfunction

   // Predicts the results that one accepted byte causes.
   function automatic void predict_byte(input line_item_type it);
      logic [7:0] c;
      logic eol, stripped;
      clp_pkg::result_type r;
      logic [8:0] count;
      c = it.line_byte;
      eol = it.end_of_line;
      stripped = eol && (c == clp_pkg::LfChar || c == clp_pkg::CrChar);
      if (cr_held) begin
         cr_held = 0;
         if (!(c == clp_pkg::LfChar && eol)) close_field();
      end
      if (!stripped) begin
         if (shadow_cfg.quotes_en && c == clp_pkg::QuoteChar) begin
            if (quote_seen) begin
               quote_seen = 0; append_content(clp_pkg::QuoteChar);
            end else if (!quoted) quoted = 1;
            else quote_seen = 1;
         end else begin
            if (quote_seen) begin
               quote_seen = 0; quoted = 0;
            end
            if (!quoted && c == shadow_cfg.delimiter) begin
               if (c == clp_pkg::CrChar && !eol) cr_held = 1;
               else close_field();
            end else begin
               append_content(c);
            end
         end
      end
      if (eol) begin
         if (quote_seen) begin
            quote_seen = 0; quoted = 0;
         end
         if (quoted) begin
            r = '0;
            r.result_kind = 1'b1; r.column = col_index; r.value_type = clp_pkg::VtNull;
            r.row_status = clp_pkg::StQuote; r.last = 1'b1;
            add_expected(r);
         end else begin
            count = col_index + 9'd1;
            add_expected(converted_field(1'b1,
               (shadow_cfg.expected_columns != 0 && count != shadow_cfg.expected_columns) ?
               clp_pkg::StMismatch : clp_pkg::StOk, 1'b1));
         end
         clear_line_state();
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.payload <= '0;
         burst_left <= 0;
         gap_left <= 0;
         clear_line_state();
      end else begin
         if (req.valid && req.ready) begin
            predict_byte(line_item_type'(req.payload));
            void'(pending_bytes.pop_front());
         end
         if (req.valid && !req.ready) begin
            // Hold the offered item.
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req.valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req.valid <= 1'b1;
            req.payload <= pending_bytes[0];
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 30);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stall pattern, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_count <= 0;
      end else if (hold_off && hold_count < 300) begin
         rsp.ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         rsp.ready <= ($urandom_range(0, 9) < 7);
      end
   end

   // Checker of results against the predicted ones.
   always @(posedge clock) begin
      clp_pkg::result_type got, want;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp.valid && rsp.ready) begin
            got = clp_pkg::result_type'(rsp.payload);
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result %h", got);
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (idle_cycles >= IdleLimit) begin
            $display("csv_line_field_parser_test failed");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [2:0] index, input logic [63:0] value);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {index, 3'b000}; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      case (index)
         clp_pkg::RegDelimiter: shadow_cfg.delimiter = value[7:0];
         clp_pkg::RegQuotes: shadow_cfg.quotes_en = value[0];
         clp_pkg::RegEmptyNull: shadow_cfg.null_on_empty = value[0];
         clp_pkg::RegExpCols: shadow_cfg.expected_columns = value[4:0];
         default: shadow_cfg.column_types = value;
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] b, input bit with_eol);
      line_item_type it;
      it.line_byte = b;
      it.end_of_line = with_eol;
      pending_bytes.insert(pending_bytes.size(), it);
   endtask

   task automatic queue_text(input string s, input bit with_eol);
      for (int i = 0; i < s.len(); i++)
         queue_byte(s[i], with_eol && (i == s.len() - 1));
   endtask

   // Waits until every queued byte is taken and every result has come.
   task automatic drain();
      while (pending_bytes.size() != 0 || req.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Picks one random field text suited to a column type.
   function automatic string random_field(input logic [3:0] t);
      string s;
      int pick;
      s = "";
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         for (int i = $urandom_range(0, 4); i > 0; i--)
            s = {s, string'(8'($urandom_range(32, 126)))};
         return s;
      end
      if (pick == 1) s = " ";
      case (t)
         clp_pkg::ColBool: begin
            case ($urandom_range(0, 7))
               0: s = {s, "true"}; 1: s = {s, "FALSE"}; 2: s = {s, "t"}; 3: s = {s, "F"};
               4: s = {s, "1"}; 5: s = {s, "0"}; 6: s = {s, "tru"}; default: s = {s, "yes"};
            endcase
         end
         clp_pkg::ColBytes: for (int i = $urandom_range(0, 6); i > 0; i--)
            s = {s, string'(8'($urandom_range(97, 122)))};
         default: begin
            case ($urandom_range(0, 5))
               0: s = {s, "-"}; 1: s = {s, "+"}; default: ;
            endcase
            for (int i = $urandom_range(($urandom_range(0, 3) == 0) ? 17 : 1,
                                        ($urandom_range(0, 3) == 0) ? 21 : 10); i > 0; i--)
               s = {s, string'(8'($urandom_range(48, 57)))};
         end
      endcase
      if ($urandom_range(0, 7) == 0) s = {s, "  "};
      return s;
   endfunction

   task automatic queue_random_line(input logic [7:0] delim);
      string line;
      int ncols;
      line = "";
      ncols = (shadow_cfg.expected_columns != 0 && $urandom_range(0, 4) != 0) ?
              shadow_cfg.expected_columns : $urandom_range(1, 18);
      for (int c = 0; c < ncols; c++) begin
         if (c > 0) line = {line, string'(delim)};
         if (shadow_cfg.quotes_en && $urandom_range(0, 6) == 0)
            line = {line, "\"", random_field(type_of_column(c[7:0])), "\"\"x\""};
         else
            line = {line, random_field(type_of_column(c[7:0]))};
      end
      case ($urandom_range(0, 5))
         0: line = {line, "\n"}; 1: line = {line, "\r\n"}; 2: line = {line, "\r"};
         3: if (shadow_cfg.quotes_en) line = {line, "\""};
         default: ;
      endcase
      if (line.len() == 0) line = "x";
      queue_text(line, 1'b1);
   endtask

   initial begin
      logic [63:0] types;
      reset = 1'b1;
      csr_psel = 0; csr_penable = 0; csr_pwrite = 0; csr_paddr = '0; csr_pwdata = '0;
      hold_off = 0;
      shadow_cfg.delimiter = 8'd44; shadow_cfg.quotes_en = 1;
      shadow_cfg.null_on_empty = 0; shadow_cfg.expected_columns = 0;
      shadow_cfg.column_types = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed lines with the reset configuration.
      queue_text("a,\"b\"\"c\",  d  ,\r\n", 1'b1);
      queue_text("\"open,x", 1'b1);
      drain();

      // Typed schema: extremes, signs, bools, unknown type code.
      csr_write(clp_pkg::RegExpCols, 64'd7);
      csr_write(clp_pkg::RegColTypes, 64'h0000_0000_0F54_3211);
      csr_write(clp_pkg::RegEmptyNull, 64'd1);
      queue_text("9223372036854775807,-2147483648,18446744073709551615,-1,TRUE,z,q\n", 1'b1);
      queue_text("-9223372036854775808,2147483648,99999999999999999999,4294967296,f,,\r", 1'b1);
      queue_text(",,", 1'b1);
      drain();

      // Carriage return as delimiter, no quotes, extreme delimiter values.
      csr_write(clp_pkg::RegDelimiter, 64'd13);
      csr_write(clp_pkg::RegQuotes, 64'd0);
      csr_write(clp_pkg::RegEmptyNull, 64'd0);
      queue_text("1\r2\r\"3\r\n", 1'b1);
      queue_text("1\r\r", 1'b1);
      drain();
      csr_write(clp_pkg::RegDelimiter, 64'd255);
      queue_text("ab", 1'b0);
      queue_byte(8'd255, 1'b0);
      queue_byte(8'd0, 1'b0);
      queue_byte(8'd128, 1'b0);
      queue_byte(clp_pkg::LfChar, 1'b1);
      drain();
      csr_write(clp_pkg::RegDelimiter, 64'd0);
      csr_write(clp_pkg::RegQuotes, 64'd1);
      queue_text("x", 1'b0);
      queue_byte(8'd0, 1'b0);
      queue_text("\"y\"", 1'b0);
      queue_byte(8'd0, 1'b1);
      drain();

      // Random phases, each with its own configuration.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: csr_write(clp_pkg::RegDelimiter, 64'd44);
            1: csr_write(clp_pkg::RegDelimiter, 64'd34);
            2: csr_write(clp_pkg::RegDelimiter, 64'd9);
            default: csr_write(clp_pkg::RegDelimiter, $urandom_range(0, 3) ? 64'd44 : 64'd59);
         endcase
         csr_write(clp_pkg::RegQuotes, 64'(phase % 3 != 2));
         csr_write(clp_pkg::RegEmptyNull, 64'(phase % 2));
         csr_write(clp_pkg::RegExpCols, (phase == 0) ? 64'd0 : (phase == 1) ? 64'd16
                                : 64'($urandom_range(1, 16)));
         types = {$urandom, $urandom};
         for (int k = 0; k < 16; k++)
            if ($urandom_range(0, 4) != 0) types[4*k +: 4] = 4'($urandom_range(0, 5));
         csr_write(clp_pkg::RegColTypes, (phase == 7) ? 64'hFFFF_FFFF_FFFF_FFFF : types);
         while (pending_bytes.size() < 40) begin
            if ($urandom_range(0, 9) == 0) begin
               queue_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end else begin
               queue_random_line(shadow_cfg.delimiter);
            end
         end
         queue_byte("x", 1'b1);
         if (phase == 3) begin
            hold_off = 1'b1;
         end
         drain();
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("csv_line_field_parser_test passed");
      end else begin
         $display("csv_line_field_parser_test failed");
      end
      $finish;
   end

endmodule
